[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[src/khm_pkg.sv]
// ---------------------------------------------------------------------------
// khm_pkg
// shared constants and types of the k-th largest selector
// ---------------------------------------------------------------------------
`default_nettype none

package khm_pkg;

  localparam int MAX_K      = 64;
  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;
  localparam int OUT_BITS   = 32;
  localparam int RANK_W     = 7;
  localparam int IDX_W      = $clog2(MAX_K);
  localparam int CHILD_W    = IDX_W + 1;

  typedef logic [VALUE_BITS-1:0] heap_val_t;
  typedef logic [IN_BITS-1:0]    in_val_t;
  typedef logic [OUT_BITS-1:0]   out_val_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CHILD_W-1:0]    child_t;

endpackage

`default_nettype wire

[src/khm_ifs.sv]
// ---------------------------------------------------------------------------
// khm channel interfaces
// valid/ready channels for input words, result words and the rank register
// ---------------------------------------------------------------------------
`default_nettype none

interface khm_in_if;
  import khm_pkg::*;
  logic    valid;
  logic    ready;
  in_val_t value;
  logic    is_last;
  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface khm_out_if;
  import khm_pkg::*;
  logic     valid;
  logic     ready;
  out_val_t kth_value;
  modport source (output valid, output kth_value, input ready);
  modport sink   (input valid, input kth_value, output ready);
endinterface

interface khm_cfg_if;
  import khm_pkg::*;
  logic  valid;
  logic  ready;
  rank_t rank_k;
  modport source (output valid, output rank_k, input ready);
  modport sink   (input valid, input rank_k, output ready);
endinterface

`default_nettype wire

[src/khm_ram.sv]
// ---------------------------------------------------------------------------
// khm_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module khm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[src/kth_largest_min_heap.sv]
// ---------------------------------------------------------------------------
// kth_largest_min_heap
// streaming top-k selector built on a min-heap in block ram
// ---------------------------------------------------------------------------
// Takes one unsigned value per input word; is_last closes a list. A min-heap
// of rank_k entries (1..64, zero reads as 1, larger saturates to 64) holds the
// largest values seen; a value strictly above the root replaces it and sinks
// down. When the closing word has been folded in, the root goes out as one
// result word (0 when the list held fewer positive values than heap entries) and
// the heap is emptied in the same step. A word that does not enter the heap
// goes from idle straight to the finishing step; one that does passes a read
// step and a compare step for each level it sinks, then the finishing step.
// In the sift loop each heap level costs one ram read of both children and
// one compare-and-write-back step.
// rank_k must be written only while idle (the block does not enforce it);
// a new value applies from the next word. A finished result may wait in
// the output register while the next list is taken in; a closing word whose
// result finds that register full holds in its last step until it empties.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kth_largest_min_heap (
  input  wire logic clk,
  input  wire logic rst,
  khm_in_if.sink    items,
  khm_out_if.source results,
  khm_cfg_if.sink   cfg
);

  import khm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,   // issue reads of both children of the current node
    S_CMP,    // pick smaller child, swap or settle
    S_DONE    // emit the result on the closing word, clear the heap
  } state_t;

  state_t            state;
  rank_t             rank_k;     // configured rank register
  rank_t             n;          // heap size latched for the word in flight
  heap_val_t         v;          // value being sunk
  logic              last_q;     // word in flight closes the list
  heap_val_t         root;       // entry 0 lives in a register
  idx_t              p;          // node currently holding v
  logic [MAX_K-1:0]  valid_bits; // entry written since last clear
  logic              out_valid;
  out_val_t          kth;

  // derived signals
  rank_t     n_next;
  heap_val_t v_in;
  child_t    l_idx;
  child_t    r_idx;
  logic      has_l;
  logic      has_r;
  heap_val_t ram_a;
  heap_val_t ram_b;
  heap_val_t lv;
  heap_val_t rv;
  logic      pick_r;
  heap_val_t cv;
  child_t    c_idx;
  logic      swap;
  logic      settle;
  logic      mem_we;
  heap_val_t mem_wdata;
  logic      out_free;
  logic      accept;
  logic      emit;

  // clamp the rank into the legal heap size
  always_comb begin
    if (rank_k == '0) begin
      n_next = rank_t'(1);
    end else if (rank_k > rank_t'(MAX_K)) begin
      n_next = rank_t'(MAX_K);
    end else begin
      n_next = rank_k;
    end
  end

  assign v_in   = heap_val_t'(items.value);
  assign accept = items.valid && items.ready;

  // children of p
  assign l_idx = {p, 1'b1};
  assign r_idx = l_idx + child_t'(1);
  assign has_l = (CHILD_W'(n) > l_idx);
  assign has_r = (CHILD_W'(n) > r_idx);

  khm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_K)
  ) u_heap_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (p),
    .wdata   (mem_wdata),
    .raddr_a (l_idx[IDX_W-1:0]),
    .raddr_b (r_idx[IDX_W-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // entries not written since the last clear read as zero
  assign lv     = valid_bits[l_idx[IDX_W-1:0]] ? ram_a : '0;
  assign rv     = (has_r && valid_bits[r_idx[IDX_W-1:0]]) ? ram_b : '0;
  // left child wins ties
  assign pick_r = has_r && (lv > rv);
  assign cv     = pick_r ? rv : lv;
  assign c_idx  = pick_r ? r_idx : l_idx;
  assign swap   = (state == S_CMP) && (v > cv);
  // v comes to rest at p
  assign settle = ((state == S_READ) && !has_l) || ((state == S_CMP) && !(v > cv));

  // root is a register; the ram only holds entries below it
  assign mem_we    = (swap || settle) && (p != '0);
  assign mem_wdata = swap ? cv : v;

  assign out_free = !out_valid || results.ready;
  // closing word hands its result to the output register
  assign emit     = (state == S_DONE) && last_q && out_free;

  assign items.ready       = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign results.valid     = out_valid;
  assign results.kth_value = kth;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rank_k     <= rank_t'(1);
      root       <= '0;
      valid_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        rank_k <= cfg.rank_k;
      end
      if (out_valid && results.ready && !emit) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        valid_bits[p] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            v      <= v_in;
            last_q <= items.is_last;
            n      <= n_next;
            p      <= '0;
            if (v_in > root) begin
              root  <= v_in;
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          // reads issued here land in S_CMP
          state <= has_l ? S_CMP : S_DONE;
        end
        S_CMP: begin
          if (swap) begin
            if (p == '0) begin
              root <= cv;
            end
            p     <= c_idx[IDX_W-1:0];
            state <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            kth        <= OUT_BITS'(root);
            root       <= '0;
            valid_bits <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the node being sunk always lies inside the heap
  `ASSERT_IMPLY(a_node_in_heap, clk, rst, state == S_READ, CHILD_W'(p) < CHILD_W'(n))
  // the root is never written through the ram
  `ASSERT_IMPLY(a_no_ram_root, clk, rst, mem_we, p != '0)
  // a result word leaves the heap empty
  `ASSERT_NEXT(a_clear_after_result, clk, rst, emit, root == '0 && valid_bits == '0)
  // result words are only raised by the finishing step
  `ASSERT_IMPLY(a_result_source, clk, rst, $rose(out_valid), $past(state == S_DONE))

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the k-th largest selector
// ---------------------------------------------------------------------------
// Words are queued by a sequencer, sent by a clocked driver with random gaps
// and folded into a local min-heap image as they are accepted. Each closing
// word adds one expected result. A clocked monitor takes the result words with
// random back-pressure and compares each one with the oldest expectation. The
// rank register is rewritten between phases, only once the block has gone
// quiet.
// ---------------------------------------------------------------------------
module tb_top;
  import khm_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int GAP_MAX        = 12;
  // settle time that covers the longest sift with ample margin
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SMALL_BUDGET   = 35;
  localparam int LARGE_BUDGET   = 60;
  localparam int PRESSURE_WORDS = 40;

  typedef struct packed {
    in_val_t value;
    logic    is_last;
  } list_word_t;

  logic clk;
  logic rst;

  khm_in_if  item_ch ();
  khm_out_if result_ch ();
  khm_cfg_if rank_ch ();

  kth_largest_min_heap i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (rank_ch)
  );

  // words waiting to be sent, and the results the heap image predicts
  list_word_t pending_words[$];
  out_val_t   kth_expected[$];

  // local image of the heap and of the rank register
  heap_val_t heap_img [MAX_K];
  rank_t     rank_now;

  int words_queued;
  int words_taken;
  int fail_cnt;
  int in_gap_max;
  int out_gap_max;
  int stall_req;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // heap size in use: zero reads as one, anything past the store saturates
  function automatic int heap_size_of(rank_t k);
    if (k == rank_t'(0)) return 1;
    if (int'(k) > MAX_K) return MAX_K;
    return int'(k);
  endfunction

  // fold one accepted word into the heap image; a closing word yields the root
  function automatic void fold_word(in_val_t value, logic is_last);
    int        n;
    int        p;
    int        l;
    int        r;
    int        c;
    bit        settled;
    heap_val_t v;
    heap_val_t t;
    n = heap_size_of(rank_now);
    v = heap_val_t'(value);
    // only a value strictly above the root gets in
    if (v > heap_img[0]) begin
      heap_img[0] = v;
      p = 0;
      settled = 1'b0;
      while (!settled) begin
        l = 2 * p + 1;
        r = l + 1;
        if (l >= n) begin
          settled = 1'b1;
        end else begin
          // smaller child, left one on a tie
          if (r >= n) c = l;
          else c = (heap_img[l] > heap_img[r]) ? r : l;
          if (heap_img[p] <= heap_img[c]) begin
            settled = 1'b1;
          end else begin
            t           = heap_img[p];
            heap_img[p] = heap_img[c];
            heap_img[c] = t;
            p           = c;
          end
        end
      end
    end
    if (is_last) begin
      kth_expected.push_back(out_val_t'(heap_img[0]));
      // list finished: the whole store empties, not just the part in use
      for (int i = 0; i < MAX_K; i++) heap_img[i] = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: sends queued words, random gap drawn per word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    list_word_t nxt;
    int         tx_gap;
    if (rst) begin
      item_ch.valid   <= 1'b0;
      item_ch.value   <= '0;
      item_ch.is_last <= 1'b0;
      tx_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        fold_word(item_ch.value, item_ch.is_last);
        words_taken++;
      end
      // slot is free when nothing is on offer or the offer was just taken
      if (!item_ch.valid || item_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          nxt = pending_words.pop_front();
          item_ch.valid   <= 1'b1;
          item_ch.value   <= nxt.value;
          item_ch.is_last <= nxt.is_last;
          tx_gap = $urandom_range(0, in_gap_max);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes result words, random back-pressure, long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    out_val_t want;
    int       rx_gap;
    int       rx_hold;
    int       stall_seen;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_gap     = 0;
      rx_hold    = 0;
      stall_seen = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (kth_expected.size() == 0) begin
          $display("%0t: kth_value %h arrived with nothing expected",
                   $time, result_ch.kth_value);
          fail_cnt++;
        end else begin
          want = kth_expected.pop_front();
          if (result_ch.kth_value !== want) begin
            $display("%0t: kth_value mismatch, expected %h, actual %h",
                     $time, want, result_ch.kth_value);
            fail_cnt++;
          end
        end
        rx_gap = $urandom_range(0, out_gap_max);
      end
      // a new request from the sequencer starts a long hold-off
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        rx_hold    = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a long run of cycles without any handshake ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_ch.valid && item_ch.ready) ||
                 (result_ch.valid && result_ch.ready) ||
                 (rank_ch.valid && rank_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("kth_largest_min_heap verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(in_val_t value, logic is_last);
    list_word_t wd;
    wd.value   = value;
    wd.is_last = is_last;
    pending_words.push_back(wd);
    words_queued++;
  endtask

  // wait until every word is taken and every result seen, then let the
  // block finish any sift still running on a word with no result
  task automatic wait_idle();
    do @(posedge clk);
    while (words_taken != words_queued || kth_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one rank write; caller makes sure the block is quiet
  task automatic write_rank(rank_t k);
    @(posedge clk);
    rank_ch.valid  <= 1'b1;
    rank_ch.rank_k <= k;
    do @(posedge clk);
    while (!rank_ch.ready);
    rank_ch.valid <= 1'b0;
    rank_now = k;
  endtask

  // mostly full-width values, with ties, zeros and all-ones mixed in
  function automatic in_val_t draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return in_val_t'($urandom());
      5, 6:          return in_val_t'($urandom_range(0, 15));
      7:             return '0;
      8:             return '1;
      default:       return in_val_t'($urandom() >> $urandom_range(1, 31));
    endcase
  endfunction

  // random lists until a word budget is met; the last list may be left open so
  // the next rank write lands mid-list
  task automatic queue_lists(int budget, int max_len, bit leave_open);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < budget) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++)
        queue_word(draw_value(),
                   (i == len - 1) && !(leave_open && cnt + len >= budget));
      cnt += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rank_t ranks [10];
    int    n;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.value   = '0;
    item_ch.is_last = 1'b0;
    result_ch.ready = 1'b0;
    rank_ch.valid   = 1'b0;
    rank_ch.rank_k  = '0;
    rank_now        = rank_t'(1);
    for (int i = 0; i < MAX_K; i++) heap_img[i] = '0;
    words_queued = 0;
    words_taken  = 0;
    fail_cnt     = 0;
    in_gap_max   = 0;
    out_gap_max  = 0;
    stall_req    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: reset rank of one, empty-ish lists, extremes, equal to root
    queue_word('0, 1'b1);
    queue_word('1, 1'b1);
    queue_word(in_val_t'(5), 1'b0);
    queue_word(in_val_t'(5), 1'b1);
    wait_idle();

    // rank four: duplicates, too few positive values, alternating bits
    write_rank(rank_t'(4));
    queue_word(in_val_t'(9), 1'b0);
    queue_word(in_val_t'(9), 1'b0);
    queue_word(in_val_t'(3), 1'b0);
    queue_word(in_val_t'(1), 1'b0);
    queue_word(in_val_t'(7), 1'b1);
    queue_word('0, 1'b0);
    queue_word(in_val_t'(6), 1'b0);
    queue_word('0, 1'b1);
    queue_word(in_val_t'(32'h5555_5555), 1'b0);
    queue_word(in_val_t'(32'hAAAA_AAAA), 1'b0);
    queue_word(in_val_t'(32'hFFFF_FFFE), 1'b0);
    queue_word(in_val_t'(1), 1'b1);
    // list left open across the next rank write
    queue_word(in_val_t'(10), 1'b0);
    queue_word(in_val_t'(20), 1'b0);
    queue_word(in_val_t'(30), 1'b0);
    wait_idle();

    // shrink mid-list: stale entries past the new size are ignored
    write_rank(rank_t'(2));
    queue_word(in_val_t'(5), 1'b0);
    queue_word(in_val_t'(40), 1'b1);
    wait_idle();

    // rank zero behaves as one
    write_rank(rank_t'(0));
    queue_word(in_val_t'(7), 1'b0);
    queue_word(in_val_t'(8), 1'b1);
    wait_idle();

    // top of the register saturates to the store depth
    write_rank(rank_t'(127));
    queue_word(in_val_t'(1), 1'b0);
    queue_word(in_val_t'(2), 1'b1);
    wait_idle();

    // random phases over a spread of ranks, extremes included
    ranks = '{rank_t'(64), rank_t'(2), rank_t'(127), rank_t'(0), rank_t'(5),
              rank_t'(16), rank_t'(3), rank_t'(1), rank_t'(0), rank_t'(0)};
    ranks[8] = rank_t'($urandom_range(0, 127));
    ranks[9] = rank_t'($urandom_range(0, 127));
    for (int p = 0; p < 10; p++) begin
      // gap mode: both idle, neither idles, or one side only
      case (p % 3)
        0: begin
          in_gap_max  = GAP_MAX;
          out_gap_max = GAP_MAX;
        end
        1: begin
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        default: begin
          in_gap_max  = $urandom_range(0, 1) ? GAP_MAX : 0;
          out_gap_max = (in_gap_max == 0) ? GAP_MAX : 0;
        end
      endcase
      write_rank(ranks[p]);
      n = heap_size_of(ranks[p]);
      queue_lists((n > 16) ? LARGE_BUDGET : SMALL_BUDGET, 2 * n + 2,
                  $urandom_range(0, 2) == 0);
      // sender holds back until every result of the phase is in
      wait_idle();

      // midway: receiver holds off while the sender keeps offering short
      // lists, so the output register fills and the input stalls
      if (p == 4) begin
        in_gap_max  = 0;
        out_gap_max = 0;
        write_rank(rank_t'($urandom_range(1, 3)));
        stall_req <= stall_req + 1;
        queue_lists(PRESSURE_WORDS, 2, 1'b0);
        wait_idle();
      end
    end

    if (fail_cnt == 0) begin
      $display("kth_largest_min_heap verification clean");
    end else begin
      $display("kth_largest_min_heap verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/khm_pkg.sv
src/khm_ifs.sv
src/khm_ram.sv
src/kth_largest_min_heap.sv
dv/tb_top.sv
